@@ rtl/core/tlp_pkg.sv @@
// Shared types and constants for the line printer port.
`timescale 1ns / 1ps

package tlp_pkg;

    localparam logic       KIND_WRITE      = 1'b0;
    localparam logic       KIND_READ       = 1'b1;
    localparam logic       RK_READ         = 1'b0;
    localparam logic       RK_LINE         = 1'b1;
    localparam logic [7:0] READ_VALUE      = 8'd191;
    localparam logic [15:0] ROW_MAX        = 16'hFFFF;
    localparam int         MOTOR_BIT       = 2;
    localparam int         POWER_BIT       = 7;
    localparam int         CFG_AW          = 1;
    localparam int         CFG_DW          = 1;
    localparam logic [CFG_AW-1:0] CFG_EMIT_ENABLE = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_ZX81_MODE   = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [4:0]  byte_index;
        logic [15:0] row_number;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        is_line;
        logic [15:0] row;
    } t_cmd;

endpackage

@@ rtl/core/tlp_fifo.sv @@
// Small register queue used between the stages and at the result side.
`timescale 1ns / 1ps

module tlp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/tlp_front.sv @@
// Front end: accepts port beats, moves the head, packs pixels, issues commands.
`timescale 1ns / 1ps

module tlp_front #(
    parameter int LINE_BYTES = 32,
    parameter int IDX_W      = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tlp_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [tlp_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                      i_push,
    input  tlp_pkg::t_item            i_item,
    output logic                      o_full,
    output logic                      o_cmd_push,
    output tlp_pkg::t_cmd             o_cmd,
    input  logic                      i_cmd_full,
    input  logic                      i_line_done,
    output logic                      o_mem_we,
    output logic [IDX_W-1:0]          o_mem_addr,
    output logic [7:0]                o_mem_wdata
);
    import tlp_pkg::*;

    localparam int DOTS  = LINE_BYTES * 8;
    localparam int POS_W = $clog2(DOTS + 3);

    // r_pos holds head position plus one: 0 means the head is parked at -1
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] pos_inc, head_idx, ret_at;
    logic [7:0]       r_acc;
    logic [15:0]      r_rows;
    logic             r_busy;
    logic             r_emit, r_zx81;
    logic             accept, is_write, motor, power, in_line, ret;

    assign o_full   = i_cmd_full | r_busy;
    assign accept   = i_push & ~o_full;
    assign is_write = (i_item.kind == KIND_WRITE);
    assign motor    = ~i_item.write_data[MOTOR_BIT];
    assign power    = i_item.write_data[POWER_BIT];
    assign pos_inc  = r_pos + 1'b1;
    assign head_idx = r_pos - 1'b1;
    assign ret_at   = r_zx81 ? POS_W'(DOTS + 2) : POS_W'(DOTS + 1);
    assign in_line  = (r_pos != '0) && (r_pos <= POS_W'(DOTS));
    assign ret      = accept & is_write & motor & (pos_inc >= ret_at);
    assign n_pos    = ret ? '0 : pos_inc;

    assign o_mem_we    = accept & is_write & motor & in_line & (head_idx[2:0] == 3'd7);
    assign o_mem_addr  = head_idx[IDX_W+2:3];
    assign o_mem_wdata = {r_acc[6:0], power};

    assign o_cmd_push  = (accept & ~is_write) | (ret & r_emit);
    assign o_cmd.is_line = is_write;
    assign o_cmd.row     = is_write ? r_rows : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_rows <= '0;
            r_busy <= 1'b0;
            r_emit <= 1'b0;
            r_zx81 <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_EMIT_ENABLE: r_emit <= i_cfg_wdata[0];
                    CFG_ZX81_MODE:   r_zx81 <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (accept && is_write && motor) begin
                r_pos <= n_pos;
            end
            if (ret && (r_rows != ROW_MAX)) begin
                r_rows <= r_rows + 1'b1;
            end
            if (ret && r_emit) begin
                r_busy <= 1'b1;
            end else if (i_line_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_write && motor) begin
            r_acc <= {r_acc[6:0], power};
        end
    end

endmodule

@@ rtl/core/tlp_back.sv @@
// Back end: line buffer and sequencer that turns commands into result beats.
`timescale 1ns / 1ps

module tlp_back #(
    parameter int LINE_BYTES = 32,
    parameter int IDX_W      = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_mem_we,
    input  logic [IDX_W-1:0]  i_mem_addr,
    input  logic [7:0]        i_mem_wdata,
    input  logic              i_cmd_valid,
    input  tlp_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_out_full,
    output logic              o_out_push,
    output tlp_pkg::t_result  o_out,
    output logic              o_line_done
);
    import tlp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [7:0]       mem [LINE_BYTES];
    logic [7:0]       r_rdata;
    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [15:0]      r_row;
    logic [IDX_W+4:0] idx_ext;
    logic             last_byte;

    assign idx_ext   = {5'd0, r_idx};
    assign last_byte = (r_idx == IDX_W'(LINE_BYTES - 1));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_cmd_pop   = 1'b0;
        o_out_push  = 1'b0;
        o_line_done = 1'b0;
        o_out.result_kind = RK_LINE;
        o_out.data_byte   = r_rdata;
        o_out.byte_index  = idx_ext[4:0];
        o_out.row_number  = r_row;
        o_out.last        = last_byte;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_line) begin
                        o_cmd_pop = 1'b1;
                        n_idx     = '0;
                        n_state   = S_WAIT;
                    end else begin
                        o_out.result_kind = RK_READ;
                        o_out.data_byte   = READ_VALUE;
                        o_out.byte_index  = 5'd0;
                        o_out.row_number  = 16'd0;
                        o_out.last        = 1'b1;
                        if (!i_out_full) begin
                            o_cmd_pop  = 1'b1;
                            o_out_push = 1'b1;
                        end
                    end
                end
            end
            S_WAIT: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    if (last_byte) begin
                        o_line_done = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_WAIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid && i_cmd.is_line) begin
            r_row <= i_cmd.row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_we) begin
            mem[i_mem_addr] <= i_mem_wdata;
        end
        r_rdata <= mem[r_idx];
    end

endmodule

@@ rtl/core/thermal_line_printer_port.sv @@
// Top level of the line printer port: front end, command queue, back end, result queue.
`timescale 1ns / 1ps

// Usage:
//   Input side is a queue: drive i_item and push; the beat is taken when full is low.
//   Result side is a queue: o_result is valid while empty is low; pop takes it.
//   Config: i_cfg_we writes i_cfg_wdata to register i_cfg_addr (0 emit enable,
//   1 ZX81 mode); change it only while the block is idle.
// Flow:
//   A port write without a carriage return gives no result.
//   A port read's result passes through the command queue and then the result queue.
//   A carriage return with emission on streams LINE_BYTES beats, each a line
//   buffer read followed by an output push, and the input stays full from
//   the carriage return until the last byte is in the result queue.
// Stall: when the result queue is full the back end holds; the two-entry command
//   queue then fills and full rises. No beat is dropped.
// Reset: synchronous, active low; head parks at -1, row count and config registers
//   clear, both queues empty. Line buffer contents are left as they are.
module thermal_line_printer_port #(
    parameter int LINE_BYTES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tlp_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [tlp_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                       push,
    input  tlp_pkg::t_item             i_item,
    output logic                       full,
    input  logic                       pop,
    output logic                       empty,
    output tlp_pkg::t_result           o_result
);
    import tlp_pkg::*;

    localparam int IDX_W = $clog2(LINE_BYTES);

    logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_cmd             cmd_in, cmd_out;
    logic             mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [7:0]       mem_wdata;
    logic             line_done;
    logic             out_push, out_full;
    t_result          out_in;

    tlp_front #(
        .LINE_BYTES (LINE_BYTES),
        .IDX_W      (IDX_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full),
        .i_line_done (line_done),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata)
    );

    tlp_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_out)
    );

    tlp_back #(
        .LINE_BYTES (LINE_BYTES),
        .IDX_W      (IDX_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mem_we    (mem_we),
        .i_mem_addr  (mem_addr),
        .i_mem_wdata (mem_wdata),
        .i_cmd_valid (~cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out       (out_in),
        .o_line_done (line_done)
    );

    tlp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule

@@ tb/thermal_line_printer_port_test.sv @@
// Self-checking testbench for the line printer port: random port traffic against a line predictor.
`timescale 1ns / 1ps

module thermal_line_printer_port_test;
    import tlp_pkg::*;

    localparam int LINE_BYTES    = 32;
    localparam int LINE_PIXELS   = LINE_BYTES * 8;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 104;
    localparam int PHASE_ITEMS   = 52;

    class print_ledger;
        t_result           beats_q[$];
        int                errors;
        logic              emit_on;
        logic              zx81_on;
        logic signed [9:0] head;
        logic              fast;
        logic              motor;
        logic              power;
        logic [7:0]        line_buf[LINE_BYTES];
        logic [2:0]        band;
        logic [15:0]       rows;

        function new();
            errors     = 0;
            emit_on    = 1'b0;
            zx81_on    = 1'b0;
            head       = -10'sd1;
            fast       = 1'b0;
            motor      = 1'b0;
            power      = 1'b0;
            band       = '0;
            rows       = '0;
            foreach (line_buf[i]) line_buf[i] = '0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            if (idx == CFG_EMIT_ENABLE) emit_on = val[0];
            else if (idx == CFG_ZX81_MODE) zx81_on = val[0];
        endfunction

        function void queue_beat(logic rk, logic [7:0] d, logic [4:0] idx,
                                 logic [15:0] row, logic lst);
            t_result r;
            r.result_kind = rk;
            r.data_byte   = d;
            r.byte_index  = idx;
            r.row_number  = row;
            r.last        = lst;
            beats_q.push_back(r);
        endfunction

        function void note_item(t_item it);
            int cr_at;
            if (it.kind == KIND_READ) begin
                queue_beat(RK_READ, READ_VALUE, 5'd0, 16'd0, 1'b1);
                return;
            end
            fast  = ~it.write_data[1];
            motor = ~it.write_data[MOTOR_BIT];
            power = it.write_data[POWER_BIT];
            if (!motor) return;
            if (head >= 0 && head < LINE_PIXELS)
                line_buf[head[7:3]][3'd7 - head[2:0]] = power;
            head  = head + 10'sd1;
            cr_at = zx81_on ? LINE_PIXELS + 1 : LINE_PIXELS;
            if (head >= cr_at) begin
                head = -10'sd1;
                if (emit_on) begin
                    for (int i = 0; i < LINE_BYTES; i++)
                        queue_beat(RK_LINE, line_buf[i], 5'(i), rows, i == LINE_BYTES - 1);
                end
                band = band + 3'd1;
                if (rows != ROW_MAX) rows = rows + 16'd1;
            end
        endfunction

        task check_result(t_result got);
            t_result w;
            if (beats_q.size() == 0) begin
                report($sformatf("beat %h with nothing pending", got));
                return;
            end
            w = beats_q.pop_front();
            if (got.result_kind !== w.result_kind)
                report($sformatf("result_kind %h, want %h", got.result_kind, w.result_kind));
            if (got.data_byte !== w.data_byte)
                report($sformatf("data_byte %h, want %h", got.data_byte, w.data_byte));
            if (got.byte_index !== w.byte_index)
                report($sformatf("byte_index %0d, want %0d", got.byte_index, w.byte_index));
            if (got.row_number !== w.row_number)
                report($sformatf("row_number %0d, want %0d", got.row_number, w.row_number));
            if (got.last !== w.last)
                report($sformatf("last %b, want %b", got.last, w.last));
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_addr;
    logic [CFG_DW-1:0]   i_cfg_wdata;
    logic                push;
    t_item               i_item;
    logic                full;
    logic                pop;
    logic                empty;
    t_result             o_result;

    print_ledger ledger = new();
    bit          no_idle  = 1'b0;
    bit          hold_req = 1'b0;
    int          stall_cycles = 0;
    int          random_sent  = 0;

    thermal_line_printer_port #(.LINE_BYTES(LINE_BYTES)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .o_result   (o_result)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("thermal_line_printer_port test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random pop gaps, one long hold-off on request
    initial begin
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) ledger.check_result(o_result);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            pop <= 1'b1;
        end
    end

    task automatic send_item(input t_item it);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        ledger.note_item(it);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (ledger.beats_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic emit, input logic zx81);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_EMIT_ENABLE;
        i_cfg_wdata <= emit;
        @(posedge i_clk);
        ledger.set_reg(CFG_EMIT_ENABLE, emit);
        i_cfg_addr  <= CFG_ZX81_MODE;
        i_cfg_wdata <= zx81;
        @(posedge i_clk);
        ledger.set_reg(CFG_ZX81_MODE, zx81);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_item motor_write();
        t_item it;
        it.kind                 = KIND_WRITE;
        it.write_data           = 8'($urandom);
        it.write_data[MOTOR_BIT] = 1'b0;
        return it;
    endfunction

    // mostly printing strobes, some reads and motor-stop writes as noise
    function automatic t_item random_item();
        t_item it;
        int    pick;
        pick = $urandom_range(0, 99);
        it   = motor_write();
        if (pick < 10) begin
            it.kind       = KIND_READ;
            it.write_data = 8'($urandom);
        end else if (pick < 18) begin
            it.write_data[MOTOR_BIT] = 1'b1;
        end
        return it;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) begin
            send_item(random_item());
            random_sent++;
        end
        drain();
    endtask

    initial begin
        logic emit_sel[7] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        logic zx_sel[7]   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        int   phase;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;
        push        <= 1'b0;
        i_item      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_config(1'b1, 1'b0);

        // reads, motor stop, head parked at -1, first pixels, motor stop mid line
        send_item(t_item'{KIND_READ,  8'h00});
        send_item(t_item'{KIND_READ,  8'hFF});
        send_item(t_item'{KIND_WRITE, 8'hFF});
        send_item(t_item'{KIND_WRITE, 8'h04});
        send_item(t_item'{KIND_WRITE, 8'h00});
        send_item(t_item'{KIND_WRITE, 8'h80});
        send_item(t_item'{KIND_WRITE, 8'h82});
        send_item(t_item'{KIND_WRITE, 8'h7B});
        send_item(t_item'{KIND_WRITE, 8'hFB});
        send_item(t_item'{KIND_WRITE, 8'h84});
        send_item(t_item'{KIND_READ,  8'h5A});
        send_item(t_item'{KIND_WRITE, 8'h00});
        send_item(t_item'{KIND_WRITE, 8'h80});
        send_item(t_item'{KIND_READ,  8'hA5});
        drain();

        // park the head at the normal return position in ZX81 mode, then leave ZX81 mode
        set_config(1'b1, 1'b1);
        while (ledger.head != 10'sd256) send_item(motor_write());
        drain();
        set_config(1'b1, 1'b0);
        // long receiver hold-off while the line streams out and a read waits
        hold_req = 1'b1;
        send_item(motor_write());
        send_item(t_item'{KIND_READ, 8'h3C});
        drain();

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            set_config(emit_sel[phase % 7], zx_sel[phase % 7]);
            random_phase(PHASE_ITEMS);
            phase++;
        end

        set_config(1'b0, 1'b0);
        random_phase(30);
        no_idle = 1'b1;
        set_config(1'b1, 1'b0);
        random_phase(60);

        if (ledger.errors == 0)
            $display("thermal_line_printer_port test passed");
        else
            $display("thermal_line_printer_port test failed");
        $finish;
    end

endmodule
